[hw/rtl/sha256_byte_stream_hasher_top_defines.svh]
// Assertion macros shared by the RTL files.
`ifndef SHA256_BYTE_STREAM_HASHER_TOP_DEFINES_SVH
`define SHA256_BYTE_STREAM_HASHER_TOP_DEFINES_SVH

// Implication checked at every clock edge outside reset.
`define SHA_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Implication checked in the cycle after the antecedent.
`define SHA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[hw/rtl/sha_pkg.sv]
package sha_pkg;

  typedef enum logic {
    OP_APPEND = 1'b0,
    OP_FINISH = 1'b1
  } op_t;

  typedef struct packed {
    logic       operation;
    logic [7:0] data_byte;
  } in_word_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_word_t;

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam int unsigned BLOCK_BYTES = 64;
  localparam int unsigned LEN_OFFSET = 56;
  localparam logic [9:0] BLOCK_BITS = 10'd512;

  localparam logic [31:0] INIT_H [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] ror32(input logic [31:0] x, input int unsigned n);
    ror32 = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] sig0(input logic [31:0] y);
    sig0 = ror32(y, 7) ^ ror32(y, 18) ^ (y >> 3);
  endfunction

  function automatic logic [31:0] sig1(input logic [31:0] x);
    sig1 = ror32(x, 17) ^ ror32(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] bsig0(input logic [31:0] a);
    bsig0 = ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22);
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] e);
    bsig1 = ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25);
  endfunction

endpackage

[hw/rtl/sha256_byte_stream_hasher_top.sv]
// SHA-256 byte stream hasher.
// Input channel in_valid/in_ready carries in_word: operation append puts
// data_byte into the block; operation finish pads, compresses and emits
// the digest. Output channel out_valid/out_ready carries eight words,
// H0 first, last_word set on H7.
// An append only writes its byte unless it fills the block; then the block is
// compressed: a start strobe, the load of the hash words, the rounds (one
// round per cycle, set by the round logic and its message schedule window),
// write-back through the hash word memory and a hand-back, after which
// in_ready returns.
// A finish runs the padding writes (up to 64 per block) and one or two
// compressions, then sends the 8 output words one at a time, each held
// on out_word until out_ready takes it.
// Reset: the initial hash values are loaded into the hash word memory first;
// in_ready rises once that load is done. The same reload follows every digest.
// While the receiver stalls, the current digest word holds on out_word and
// no new input is taken until all eight words have gone.
module sha256_byte_stream_hasher_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  sha_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_ready,
  output sha_pkg::out_word_t out_word
);
  import sha_pkg::*;

  typedef enum logic [2:0] {
    T_IDLE, T_COMP, T_PAD, T_OUT, T_INIT
  } tstate_t;

  tstate_t     state;
  logic [5:0]  fill;
  logic [63:0] msg_bits;
  logic [63:0] total;
  logic [5:0]  pad_ptr;
  logic        second;
  logic        finishing;
  logic [2:0]  oidx;
  logic        oprim;
  logic        core_start;
  logic        core_init;
  logic        core_busy;
  logic [3:0]  blk_addr;
  logic [31:0] blk_data;
  logic [31:0] dig_data;
  logic [7:0]  pad_byte;
  logic [7:0]  bwd;
  logic [5:0]  bwa;
  logic        bwe;
  logic [7:0]  rd0, rd1, rd2, rd3;

  // block buffer as four byte lanes so a whole word is read from one address
  for (genvar g = 0; g < 4; g++) begin : g_lane
    logic [7:0] rdg;
    sha_ram #(.WIDTH(8), .DEPTH(16)) u_lane (
      .clk(clk), .wr_en(bwe && bwa[1:0] == 2'(g)), .wr_addr(bwa[5:2]),
      .wr_data(bwd), .rd_addr(blk_addr), .rd_data(rdg)
    );
  end
  assign rd0 = g_lane[0].rdg;
  assign rd1 = g_lane[1].rdg;
  assign rd2 = g_lane[2].rdg;
  assign rd3 = g_lane[3].rdg;
  assign blk_data = {rd0, rd1, rd2, rd3};

  sha_core u_core (
    .clk(clk), .rst(rst), .start(core_start), .init_hash(core_init),
    .busy(core_busy), .blk_addr(blk_addr), .blk_data(blk_data),
    .dig_addr(oidx), .dig_data(dig_data)
  );

  assign total = msg_bits + {55'd0, fill, 3'd0};
  assign in_ready = (state == T_IDLE) && !core_busy;

  always_comb begin
    if (pad_ptr == fill && !second) begin
      pad_byte = PAD_BYTE;
    end else if (pad_ptr >= 6'(LEN_OFFSET) && (fill < 6'(LEN_OFFSET) || second)) begin
      pad_byte = total[8'(63) - {2'd0, pad_ptr[2:0], 3'd0} -: 8];
    end else begin
      pad_byte = 8'd0;
    end
    bwe = 1'b0;
    bwa = fill;
    bwd = in_word.data_byte;
    if (state == T_IDLE && in_valid && in_ready && in_word.operation == OP_APPEND) begin
      bwe = 1'b1;
    end else if (state == T_PAD) begin
      bwe = 1'b1;
      bwa = pad_ptr;
      bwd = pad_byte;
    end
  end

  always_comb begin
    out_word.digest_word = dig_data;
    out_word.word_index = oidx;
    out_word.last_word = (oidx == 3'd7);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= T_INIT;
      fill <= '0;
      msg_bits <= '0;
      pad_ptr <= '0;
      second <= 1'b0;
      finishing <= 1'b0;
      oidx <= '0;
      oprim <= 1'b0;
      out_valid <= 1'b0;
      core_start <= 1'b0;
      core_init <= 1'b0;
    end else begin
      core_start <= 1'b0;
      core_init <= 1'b0;
      case (state)
        T_INIT: begin
          if (!core_busy) begin
            state <= T_IDLE;
          end
        end
        T_IDLE: begin
          if (in_valid && in_ready) begin
            if (in_word.operation == OP_APPEND) begin
              fill <= fill + 6'd1;
              if (fill == 6'd63) begin
                core_start <= 1'b1;
                msg_bits <= msg_bits + 64'(BLOCK_BITS);
                finishing <= 1'b0;
                state <= T_COMP;
              end
            end else begin
              pad_ptr <= fill;
              second <= 1'b0;
              state <= T_PAD;
            end
          end
        end
        T_PAD: begin
          pad_ptr <= pad_ptr + 6'd1;
          if (pad_ptr == 6'd63) begin
            core_start <= 1'b1;
            // first of two blocks when length does not fit
            finishing <= second || fill < 6'(LEN_OFFSET);
            state <= T_COMP;
          end
        end
        T_COMP: begin
          if (!core_start && !core_busy) begin
            if (finishing) begin
              state <= T_OUT;
              oidx <= '0;
              oprim <= 1'b1;
            end else if (pad_ptr == 6'd0 && fill >= 6'(LEN_OFFSET) && !second) begin
              second <= 1'b1;
              state <= T_PAD;
            end else begin
              state <= T_IDLE;
            end
          end
        end
        T_OUT: begin
          if (oprim) begin
            oprim <= 1'b0;
            out_valid <= 1'b1;
          end else if (out_valid && out_ready) begin
            out_valid <= 1'b0;
            if (oidx == 3'd7) begin
              fill <= '0;
              msg_bits <= '0;
              second <= 1'b0;
              finishing <= 1'b0;
              core_init <= 1'b1;
              state <= T_INIT;
            end else begin
              oidx <= oidx + 3'd1;
              oprim <= 1'b1;
            end
          end
        end
        default: state <= T_IDLE;
      endcase
    end
  end

  `SHA_ASSERT_IMP(a_out_only, clk, rst, out_valid, state == T_OUT)
  `SHA_ASSERT_IMP(a_no_in_busy, clk, rst, in_ready, !core_busy && state == T_IDLE)
  `SHA_ASSERT_NEXT(a_last_leaves, clk, rst, out_valid && out_ready && oidx == 3'd7, !out_valid)

endmodule

[hw/rtl/sha_ram.sv]
module sha_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[hw/rtl/sha_core.sv]
`include "sha256_byte_stream_hasher_top_defines.svh"

// Compression engine. Reads the 16 block words from the word memory, keeps the
// message schedule in a 16-word shift window and runs one round per cycle.
// Hash words live in a second memory, read and written back one per cycle.
module sha_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        init_hash,
  output logic        busy,
  // block word memory read port
  output logic [3:0]  blk_addr,
  input  logic [31:0] blk_data,
  // hash word read port for the digest
  input  logic [2:0]  dig_addr,
  output logic [31:0] dig_data
);
  import sha_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_INIT, S_LOADH, S_ROUND, S_FOLD
  } state_t;

  state_t      state;
  logic [6:0]  cnt;
  logic [31:0] v [8];
  logic [31:0] w [16];
  logic        h_we;
  logic [2:0]  h_waddr;
  logic [31:0] h_wdata;
  logic [2:0]  h_raddr;
  logic [31:0] h_rdata;
  logic [31:0] w_cur;
  logic [31:0] w_new;
  logic [31:0] t1;
  logic [31:0] t2;
  logic [31:0] vs;

  sha_ram #(.WIDTH(32), .DEPTH(8)) u_hash (
    .clk(clk), .wr_en(h_we), .wr_addr(h_waddr), .wr_data(h_wdata),
    .rd_addr(h_raddr), .rd_data(h_rdata)
  );

  assign busy = (state != S_IDLE);
  assign dig_data = h_rdata;
  // word 0 is fetched during the hash load so round 1 finds it ready
  assign blk_addr = (state == S_ROUND) ? cnt[3:0] : 4'd0;

  // round word: memory data for the first 16 rounds, else schedule
  assign w_new = sig1(w[14]) + w[9] + sig0(w[1]) + w[0];
  assign w_cur = (cnt < 7'd17) ? blk_data : w_new;
  assign t1 = v[7] + bsig1(v[4]) + ((v[4] & v[5]) ^ (~v[4] & v[6]))
              + ROUND_K[cnt[5:0] - 6'd1] + w_cur;
  assign t2 = bsig0(v[0]) + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));

  always_comb begin
    h_raddr = dig_addr;
    h_we = 1'b0;
    h_waddr = cnt[2:0];
    h_wdata = INIT_H[cnt[2:0]];
    vs = v[0];
    case (cnt[2:0])
      3'd0: vs = v[0];
      3'd1: vs = v[1];
      3'd2: vs = v[2];
      3'd3: vs = v[3];
      3'd4: vs = v[4];
      3'd5: vs = v[5];
      3'd6: vs = v[6];
      default: vs = v[7];
    endcase
    case (state)
      S_INIT: h_we = 1'b1;
      S_LOADH: h_raddr = cnt[2:0];
      // H0 must be on the read port when the fold starts
      S_ROUND: h_raddr = 3'd0;
      S_FOLD: begin
        h_raddr = cnt[2:0] + 3'd1;
        h_we = 1'b1;
        h_wdata = h_rdata + vs;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      cnt <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          cnt <= '0;
          if (init_hash) begin
            state <= S_INIT;
          end else if (start) begin
            state <= S_LOADH;
          end
        end
        S_INIT: begin
          cnt <= cnt + 7'd1;
          if (cnt[2:0] == 3'd7) begin
            state <= S_IDLE;
          end
        end
        S_LOADH: begin
          // address issued at cnt, data arrives at cnt+1
          if (cnt != 7'd0) begin
            v[cnt[2:0] - 3'd1] <= h_rdata;
          end
          if (cnt == 7'd8) begin
            state <= S_ROUND;
            cnt <= 7'd1;
          end else begin
            cnt <= cnt + 7'd1;
          end
        end
        S_ROUND: begin
          for (int i = 0; i < 15; i++) begin
            w[i] <= w[i + 1];
          end
          w[15] <= w_cur;
          v[7] <= v[6]; v[6] <= v[5]; v[5] <= v[4]; v[4] <= v[3] + t1;
          v[3] <= v[2]; v[2] <= v[1]; v[1] <= v[0]; v[0] <= t1 + t2;
          if (cnt == 7'd64) begin
            state <= S_FOLD;
            cnt <= '0;
          end else begin
            cnt <= cnt + 7'd1;
          end
        end
        S_FOLD: begin
          cnt <= cnt + 7'd1;
          if (cnt[2:0] == 3'd7) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `SHA_ASSERT_IMP(a_start_idle, clk, rst, start && busy, 1'b0)
  `SHA_ASSERT_IMP(a_round_cnt, clk, rst, state == S_ROUND, cnt != 7'd0 && cnt <= 7'd64)
  `SHA_ASSERT_NEXT(a_fold_done, clk, rst, state == S_FOLD && cnt[2:0] == 3'd7, !busy)

endmodule
